// ===== sv/trd_pkg.sv =====
// Shared types, constants and state codes of the triangle raster depth-test block.
package trd_pkg;

  // Screen geometry and store shape
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;
  localparam int X_W           = $clog2(SCREEN_WIDTH);
  localparam int Y_W           = $clog2(SCREEN_HEIGHT);
  localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(PIX_COUNT);

  // Field widths
  localparam int COORD_W  = 12;
  localparam int DEPTH_W  = 16;
  localparam int COLOUR_W = 32;
  localparam int COUNT_W  = 15;

  // Datapath widths: doubled coordinates, edge products, weights, numerator
  localparam int DBL_W  = COORD_W + 2;
  localparam int DIFF_W = DBL_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int EDGE_W = PROD_W + 1;
  localparam int WGT_W  = 28;
  localparam int NUM_W  = WGT_W + DEPTH_W + 2;
  localparam int QCNT_W = $clog2(DEPTH_W);

  // Item modes
  localparam logic [1:0] MODE_DRAW   = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DEGEN     = 2'd1;
  localparam logic [1:0] ST_OFFSCREEN = 2'd2;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [COORD_W-1:0]  ax;
    logic signed [COORD_W-1:0]  ay;
    logic [DEPTH_W-1:0]         az_inv;
    logic signed [COORD_W-1:0]  bx;
    logic signed [COORD_W-1:0]  by_row;
    logic [DEPTH_W-1:0]         bz_inv;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic [DEPTH_W-1:0]         cz_inv;
    logic [COLOUR_W-1:0]        fill_colour;
  } in_item_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] read_colour;
    logic [DEPTH_W-1:0]  read_depth;
    logic [COUNT_W-1:0]  pixels_written;
    logic [1:0]          status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_AREA,
    S_BOX,
    S_EDGE,
    S_COVER,
    S_WMUL,
    S_SUM,
    S_DIV,
    S_WRITE,
    S_RDADDR,
    S_RDDATA,
    S_CLEAR,
    S_DONE
  } state_e;

endpackage

// ===== sv/triangle_raster_depth_test.sv =====
// Triangle rasterizer with inverse-depth test over a colour store and a depth store.
//
// One transaction at a time. After reset the block sweeps both stores to zero, one entry a
// cycle over all PIX_COUNT = 16384 entries, and stalls its input meanwhile; a clear
// transaction runs the same sweep. A draw takes the area and the box, then walks the clamped
// bounding box one pixel at a time: an uncovered pixel takes the edge and cover steps, and a
// covered one also the 16-step quotient unit that divides the weighted depth sum by the
// area, plus the read-modify-write of the depth store. A read goes through the registered
// store read port. A finished result waits in the output register while the next one is taken.
module triangle_raster_depth_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  trd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trd_pkg::out_item_t  out_data_o
);

  // Helpers
  function automatic logic signed [trd_pkg::DBL_W-1:0] dbl(
      logic signed [trd_pkg::COORD_W-1:0] v);
    return {{2{v[trd_pkg::COORD_W-1]}}, v} <<< 1;
  endfunction

  function automatic logic signed [trd_pkg::DIFF_W-1:0] sub(
      logic signed [trd_pkg::DBL_W-1:0] a, logic signed [trd_pkg::DBL_W-1:0] b);
    return {a[trd_pkg::DBL_W-1], a} - {b[trd_pkg::DBL_W-1], b};
  endfunction

  function automatic logic signed [trd_pkg::COORD_W-1:0] min3(
      logic signed [trd_pkg::COORD_W-1:0] a, logic signed [trd_pkg::COORD_W-1:0] b,
      logic signed [trd_pkg::COORD_W-1:0] c);
    logic signed [trd_pkg::COORD_W-1:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  function automatic logic signed [trd_pkg::COORD_W-1:0] max3(
      logic signed [trd_pkg::COORD_W-1:0] a, logic signed [trd_pkg::COORD_W-1:0] b,
      logic signed [trd_pkg::COORD_W-1:0] c);
    logic signed [trd_pkg::COORD_W-1:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  // True when a non-negative coordinate lies beyond the last column or row
  function automatic logic beyond(logic signed [trd_pkg::COORD_W-1:0] v,
                                  logic [trd_pkg::COORD_W-1:0] last);
    return !v[trd_pkg::COORD_W-1] && ($unsigned(v) > last);
  endfunction

  localparam logic [trd_pkg::COORD_W-1:0] LAST_X = trd_pkg::COORD_W'(trd_pkg::SCREEN_WIDTH - 1);
  localparam logic [trd_pkg::COORD_W-1:0] LAST_Y = trd_pkg::COORD_W'(trd_pkg::SCREEN_HEIGHT - 1);

  // State and registers
  trd_pkg::state_e               state_q, state_d;
  trd_pkg::in_item_t             item_q;
  trd_pkg::out_item_t            res_q, out_q;
  logic                          out_valid_q;
  logic [trd_pkg::ADDR_W-1:0]    clr_q;
  logic [trd_pkg::X_W-1:0]       x_q, x0_q, x1_q;
  logic [trd_pkg::Y_W-1:0]       y_q, y1_q;
  logic signed [trd_pkg::PROD_W-1:0] prod_q [6];
  logic signed [trd_pkg::PROD_W-1:0] prod_d [6];
  logic signed [trd_pkg::EDGE_W-1:0] area_q;
  logic [trd_pkg::WGT_W-1:0]     w_q [3];
  logic [trd_pkg::WGT_W-1:0]     w_d [3];
  logic [trd_pkg::WGT_W+trd_pkg::DEPTH_W-1:0] mz_q [3];
  logic [trd_pkg::NUM_W-1:0]     rem_q, dsr_q;
  logic [trd_pkg::DEPTH_W-1:0]   quo_q;
  logic [trd_pkg::QCNT_W-1:0]    qcnt_q;
  logic [trd_pkg::COLOUR_W-1:0]  rd_col_q;
  logic [trd_pkg::DEPTH_W-1:0]   rd_dep_q;

  // Stores
  logic [trd_pkg::COLOUR_W-1:0]  colour_mem [trd_pkg::PIX_COUNT];
  logic [trd_pkg::DEPTH_W-1:0]   depth_mem  [trd_pkg::PIX_COUNT];

  // Handshake
  logic in_fire, out_free;
  assign in_stall_o  = (state_q != trd_pkg::S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Read address check on the incoming transaction
  logic rd_onscreen;
  assign rd_onscreen = !in_data_i.ax[trd_pkg::COORD_W-1] && !beyond(in_data_i.ax, LAST_X) &&
                       !in_data_i.ay[trd_pkg::COORD_W-1] && !beyond(in_data_i.ay, LAST_Y);

  // Doubled vertices and pixel centre
  logic signed [trd_pkg::DBL_W-1:0] xa, ya, xb, yb, xc, yc, pt_x, pt_y;
  assign xa = dbl(item_q.ax);
  assign ya = dbl(item_q.ay);
  assign xb = dbl(item_q.bx);
  assign yb = dbl(item_q.by_row);
  assign xc = dbl(item_q.cx);
  assign yc = dbl(item_q.cy);

  // Use vertex three as the point while taking the area
  always_comb begin
    if (state_q == trd_pkg::S_AREA) begin
      pt_x = xc;
      pt_y = yc;
    end else begin
      pt_x = trd_pkg::DBL_W'({x_q, 1'b1});
      pt_y = trd_pkg::DBL_W'({y_q, 1'b1});
    end
  end

  // Edge products, one pair per edge
  always_comb begin
    prod_d[0] = sub(pt_x, xa) * sub(yb, ya);
    prod_d[1] = sub(pt_y, ya) * sub(xb, xa);
    prod_d[2] = sub(pt_x, xb) * sub(yc, yb);
    prod_d[3] = sub(pt_y, yb) * sub(xc, xb);
    prod_d[4] = sub(pt_x, xc) * sub(ya, yc);
    prod_d[5] = sub(pt_y, yc) * sub(xa, xc);
  end

  // Area and bounding box
  logic signed [trd_pkg::EDGE_W-1:0] area_d;
  logic                              area_neg;
  logic [trd_pkg::WGT_W-1:0]         area_abs;
  logic signed [trd_pkg::COORD_W-1:0] bx_min, bx_max, by_min, by_max;
  logic                              box_off;
  logic [trd_pkg::X_W-1:0]           x0_c, x1_c;
  logic [trd_pkg::Y_W-1:0]           y0_c, y1_c;

  assign area_d   = trd_pkg::EDGE_W'(prod_q[0]) - trd_pkg::EDGE_W'(prod_q[1]);
  assign area_neg = area_q[trd_pkg::EDGE_W-1];
  assign area_abs = area_neg ? trd_pkg::WGT_W'(-area_q) : trd_pkg::WGT_W'(area_q);
  assign bx_min   = min3(item_q.ax, item_q.bx, item_q.cx);
  assign bx_max   = max3(item_q.ax, item_q.bx, item_q.cx);
  assign by_min   = min3(item_q.ay, item_q.by_row, item_q.cy);
  assign by_max   = max3(item_q.ay, item_q.by_row, item_q.cy);
  assign box_off  = bx_max[trd_pkg::COORD_W-1] || by_max[trd_pkg::COORD_W-1] ||
                    beyond(bx_min, LAST_X) || beyond(by_min, LAST_Y);

  // Clamp the box to the screen
  always_comb begin
    x0_c = bx_min[trd_pkg::COORD_W-1] ? '0 : trd_pkg::X_W'(bx_min);
    x1_c = beyond(bx_max, LAST_X) ? trd_pkg::X_W'(LAST_X) : trd_pkg::X_W'(bx_max);
    y0_c = by_min[trd_pkg::COORD_W-1] ? '0 : trd_pkg::Y_W'(by_min);
    y1_c = beyond(by_max, LAST_Y) ? trd_pkg::Y_W'(LAST_Y) : trd_pkg::Y_W'(by_max);
  end

  // Coverage and normalized weights
  logic signed [trd_pkg::EDGE_W-1:0] e [3];
  logic all_pos, all_neg, covered;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e[k]   = trd_pkg::EDGE_W'(prod_q[2*k]) - trd_pkg::EDGE_W'(prod_q[2*k+1]);
      w_d[k] = area_neg ? trd_pkg::WGT_W'(-e[k]) : trd_pkg::WGT_W'(e[k]);
    end
    all_pos = !e[0][trd_pkg::EDGE_W-1] && !e[1][trd_pkg::EDGE_W-1] &&
              !e[2][trd_pkg::EDGE_W-1];
    all_neg = e[0][trd_pkg::EDGE_W-1] && e[1][trd_pkg::EDGE_W-1] &&
              e[2][trd_pkg::EDGE_W-1];
    covered = area_neg ? all_neg : all_pos;
  end

  // Pixel walk, store address and depth compare
  logic                       last_pix, last_clr, nearer, rem_ge;
  logic [trd_pkg::Y_W-1:0]    row;
  logic [trd_pkg::ADDR_W-1:0] pix_idx;
  assign last_pix = (x_q == x1_q) && (y_q == y1_q);
  assign last_clr = (clr_q == trd_pkg::ADDR_W'(trd_pkg::PIX_COUNT - 1));
  assign nearer   = quo_q > rd_dep_q;
  assign rem_ge   = rem_q >= dsr_q;
  assign row      = trd_pkg::Y_W'(trd_pkg::SCREEN_HEIGHT - 1) - y_q;
  assign pix_idx  = trd_pkg::ADDR_W'(row) * trd_pkg::ADDR_W'(trd_pkg::SCREEN_WIDTH) +
                    trd_pkg::ADDR_W'(x_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trd_pkg::S_INIT:   if (last_clr) state_d = trd_pkg::S_IDLE;
      trd_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.mode)
            trd_pkg::MODE_DRAW:  state_d = trd_pkg::S_AREA;
            trd_pkg::MODE_READ:  state_d = rd_onscreen ? trd_pkg::S_RDADDR : trd_pkg::S_DONE;
            trd_pkg::MODE_CLEAR: state_d = trd_pkg::S_CLEAR;
            default:             state_d = trd_pkg::S_DONE;
          endcase
        end
      end
      trd_pkg::S_AREA:   state_d = trd_pkg::S_BOX;
      trd_pkg::S_BOX:    state_d = (area_d == '0 || box_off) ? trd_pkg::S_DONE : trd_pkg::S_EDGE;
      trd_pkg::S_EDGE:   state_d = trd_pkg::S_COVER;
      trd_pkg::S_COVER: begin
        if (covered) state_d = trd_pkg::S_WMUL;
        else         state_d = last_pix ? trd_pkg::S_DONE : trd_pkg::S_EDGE;
      end
      trd_pkg::S_WMUL:   state_d = trd_pkg::S_SUM;
      trd_pkg::S_SUM:    state_d = trd_pkg::S_DIV;
      trd_pkg::S_DIV:    if (qcnt_q == '0) state_d = trd_pkg::S_WRITE;
      trd_pkg::S_WRITE:  state_d = last_pix ? trd_pkg::S_DONE : trd_pkg::S_EDGE;
      trd_pkg::S_RDADDR: state_d = trd_pkg::S_RDDATA;
      trd_pkg::S_RDDATA: state_d = trd_pkg::S_DONE;
      trd_pkg::S_CLEAR:  if (last_clr) state_d = trd_pkg::S_DONE;
      trd_pkg::S_DONE:   if (out_free) state_d = trd_pkg::S_IDLE;
      default:           state_d = trd_pkg::S_IDLE;
    endcase
  end

  // State outputs
  logic sweep, mem_we, mem_re, step_pix, load_out;
  logic [trd_pkg::ADDR_W-1:0]   mem_addr;
  logic [trd_pkg::COLOUR_W-1:0] wr_col;
  logic [trd_pkg::DEPTH_W-1:0]  wr_dep;
  always_comb begin
    sweep    = (state_q == trd_pkg::S_INIT) || (state_q == trd_pkg::S_CLEAR);
    mem_we   = sweep || ((state_q == trd_pkg::S_WRITE) && nearer);
    mem_re   = (state_q == trd_pkg::S_EDGE) || (state_q == trd_pkg::S_RDADDR);
    step_pix = ((state_q == trd_pkg::S_COVER) && !covered) || (state_q == trd_pkg::S_WRITE);
    load_out = (state_q == trd_pkg::S_DONE) && out_free;
    mem_addr = sweep ? clr_q : pix_idx;
    wr_col   = sweep ? '0 : item_q.fill_colour;
    wr_dep   = sweep ? '0 : quo_q;
  end

  // Store ports: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      colour_mem[mem_addr] <= wr_col;
      depth_mem[mem_addr]  <= wr_dep;
    end
    if (mem_re) begin
      rd_col_q <= colour_mem[mem_addr];
      rd_dep_q <= depth_mem[mem_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trd_pkg::S_INIT;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q <= state_d;
      if (sweep) clr_q <= last_clr ? '0 : clr_q + 1'b1;
      if (load_out)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) prod_q[k] <= prod_d[k];

    if (in_fire) begin
      item_q               <= in_data_i;
      res_q.read_colour    <= '0;
      res_q.read_depth     <= '0;
      res_q.pixels_written <= '0;
      res_q.status         <= (in_data_i.mode == trd_pkg::MODE_READ && !rd_onscreen) ?
                              trd_pkg::ST_OFFSCREEN : trd_pkg::ST_OK;
      x_q                  <= trd_pkg::X_W'(in_data_i.ax);
      y_q                  <= trd_pkg::Y_W'(in_data_i.ay);
    end

    // Latch area and start the walk at the box corner
    if (state_q == trd_pkg::S_BOX) begin
      area_q <= area_d;
      x0_q   <= x0_c;
      x1_q   <= x1_c;
      y1_q   <= y1_c;
      x_q    <= x0_c;
      y_q    <= y0_c;
      if (area_d == '0) res_q.status <= trd_pkg::ST_DEGEN;
    end

    if (state_q == trd_pkg::S_COVER) begin
      for (int k = 0; k < 3; k++) w_q[k] <= w_d[k];
    end

    // Weight each vertex depth by the edge opposite it
    if (state_q == trd_pkg::S_WMUL) begin
      mz_q[0] <= w_q[1] * item_q.az_inv;
      mz_q[1] <= w_q[2] * item_q.bz_inv;
      mz_q[2] <= w_q[0] * item_q.cz_inv;
    end

    if (state_q == trd_pkg::S_SUM) begin
      rem_q  <= trd_pkg::NUM_W'(mz_q[0]) + trd_pkg::NUM_W'(mz_q[1]) +
                trd_pkg::NUM_W'(mz_q[2]);
      dsr_q  <= trd_pkg::NUM_W'(area_abs) << (trd_pkg::DEPTH_W - 1);
      quo_q  <= '0;
      qcnt_q <= trd_pkg::QCNT_W'(trd_pkg::DEPTH_W - 1);
    end

    // Restoring division, one quotient bit a cycle
    if (state_q == trd_pkg::S_DIV) begin
      if (rem_ge) rem_q <= rem_q - dsr_q;
      quo_q  <= {quo_q[trd_pkg::DEPTH_W-2:0], rem_ge};
      dsr_q  <= dsr_q >> 1;
      qcnt_q <= qcnt_q - 1'b1;
    end

    if ((state_q == trd_pkg::S_WRITE) && nearer && (res_q.pixels_written != '1))
      res_q.pixels_written <= res_q.pixels_written + 1'b1;

    // Advance along the row, then to the next row
    if (step_pix) begin
      if (x_q == x1_q) begin
        x_q <= x0_q;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end

    if (state_q == trd_pkg::S_RDDATA) begin
      res_q.read_colour <= rd_col_q;
      res_q.read_depth  <= rd_dep_q;
    end

    if (load_out) out_q <= res_q;
  end

  // Checks
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> state_q == trd_pkg::S_IDLE)
    else $error("transaction taken outside idle");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == trd_pkg::S_WRITE || state_q == trd_pkg::S_INIT ||
                state_q == trd_pkg::S_CLEAR))
    else $error("store written outside a write state");

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == trd_pkg::S_WMUL |->
      (30'(w_q[0]) + 30'(w_q[1]) + 30'(w_q[2])) == 30'(area_abs))
    else $error("edge weights do not sum to the area");

  a_walk_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == trd_pkg::S_EDGE |-> (x_q >= x0_q && x_q <= x1_q && y_q <= y1_q))
    else $error("pixel walk left the bounding box");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == trd_pkg::S_WRITE |-> $past(state_q) == trd_pkg::S_DIV)
    else $error("depth write without a finished quotient");

endmodule

// ===== dv/triangle_raster_depth_test_tb.sv =====
// Self-checking testbench for the triangle rasterizer with depth test, using random stalls.
`timescale 1ns / 100ps

module triangle_raster_depth_test_tb;

  localparam longint CYCLE_LIMIT = 6_000_000;
  localparam int     MAX_REPORTS = 10;
  localparam int     RAW_W       = 160;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  trd_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  trd_pkg::out_item_t out_data_o;

  triangle_raster_depth_test DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of both stores
  logic [trd_pkg::COLOUR_W-1:0] shadow_colour [trd_pkg::PIX_COUNT];
  logic [trd_pkg::DEPTH_W-1:0]  shadow_depth  [trd_pkg::PIX_COUNT];

  trd_pkg::in_item_t  pending_q [$];
  trd_pkg::out_item_t expected_q [$];

  int     mismatches;
  int     results_seen;
  int     draws_sent;
  int     reads_sent;
  int     clears_sent;
  int     in_gap;
  int     out_gap;
  longint cycles;

  // Edge value of point p against directed edge a->b, doubled units
  function automatic longint edge_value(longint xa, longint ya, longint xb, longint yb,
                                        longint px, longint py);
    return (px - xa) * (yb - ya) - (py - ya) * (xb - xa);
  endfunction

  function automatic void wipe_stores();
    for (int i = 0; i < trd_pkg::PIX_COUNT; i++) begin
      shadow_colour[i] = '0;
      shadow_depth[i]  = '0;
    end
  endfunction

  // Random payload bits for fields that do not matter
  function automatic trd_pkg::in_item_t random_item();
    logic [RAW_W-1:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(trd_pkg::in_item_t)-1:0];
  endfunction

  // Rasterize one triangle into the shadow stores; returns the write count
  function automatic int raster_triangle(trd_pkg::in_item_t it, output logic [1:0] st);
    longint xa, ya, xb, yb, xc, yc, area, x0, x1, y0, y1;
    longint e1, e2, e3, ar, num, z;
    int     count;
    int     idx;
    xa = 2 * longint'($signed(it.ax));  ya = 2 * longint'($signed(it.ay));
    xb = 2 * longint'($signed(it.bx));  yb = 2 * longint'($signed(it.by_row));
    xc = 2 * longint'($signed(it.cx));  yc = 2 * longint'($signed(it.cy));
    count = 0;
    st = trd_pkg::ST_OK;
    area = edge_value(xa, ya, xb, yb, xc, yc);
    if (area == 0) begin
      st = trd_pkg::ST_DEGEN;
      return 0;
    end
    x0 = xa; if (xb < x0) x0 = xb; if (xc < x0) x0 = xc;
    x1 = xa; if (xb > x1) x1 = xb; if (xc > x1) x1 = xc;
    y0 = ya; if (yb < y0) y0 = yb; if (yc < y0) y0 = yc;
    y1 = ya; if (yb > y1) y1 = yb; if (yc > y1) y1 = yc;
    x0 = x0 / 2; x1 = x1 / 2; y0 = y0 / 2; y1 = y1 / 2;
    if (x1 < 0 || y1 < 0 || x0 > trd_pkg::SCREEN_WIDTH - 1 ||
        y0 > trd_pkg::SCREEN_HEIGHT - 1) return 0;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > trd_pkg::SCREEN_WIDTH - 1) x1 = trd_pkg::SCREEN_WIDTH - 1;
    if (y1 > trd_pkg::SCREEN_HEIGHT - 1) y1 = trd_pkg::SCREEN_HEIGHT - 1;
    for (longint y = y0; y <= y1; y++) begin
      for (longint x = x0; x <= x1; x++) begin
        e1 = edge_value(xa, ya, xb, yb, 2 * x + 1, 2 * y + 1);
        e2 = edge_value(xb, yb, xc, yc, 2 * x + 1, 2 * y + 1);
        e3 = edge_value(xc, yc, xa, ya, 2 * x + 1, 2 * y + 1);
        ar = area;
        if (!((e1 >= 0 && e2 >= 0 && e3 >= 0) || (e1 < 0 && e2 < 0 && e3 < 0))) continue;
        if (ar < 0) begin
          e1 = -e1; e2 = -e2; e3 = -e3; ar = -ar;
        end
        if (e1 < 0 || e2 < 0 || e3 < 0) continue;
        num = e2 * longint'(it.az_inv) + e3 * longint'(it.bz_inv) + e1 * longint'(it.cz_inv);
        z = num / ar;
        idx = int'((trd_pkg::SCREEN_HEIGHT - 1 - y) * trd_pkg::SCREEN_WIDTH + x);
        if (z > longint'(shadow_depth[idx])) begin
          shadow_depth[idx]  = z[trd_pkg::DEPTH_W-1:0];
          shadow_colour[idx] = it.fill_colour;
          if (count < 32767) count++;
        end
      end
    end
    return count;
  endfunction

  // Expected result of one transaction; updates the shadow stores
  function automatic trd_pkg::out_item_t predict_result(trd_pkg::in_item_t it);
    trd_pkg::out_item_t r;
    logic [1:0]         st;
    int                 x, y, idx;
    r = '0;
    case (it.mode)
      trd_pkg::MODE_DRAW: begin
        r.pixels_written = trd_pkg::COUNT_W'(raster_triangle(it, st));
        r.status = st;
      end
      trd_pkg::MODE_READ: begin
        x = $signed(it.ax);
        y = $signed(it.ay);
        if (x >= 0 && x < trd_pkg::SCREEN_WIDTH && y >= 0 && y < trd_pkg::SCREEN_HEIGHT) begin
          idx = (trd_pkg::SCREEN_HEIGHT - 1 - y) * trd_pkg::SCREEN_WIDTH + x;
          r.read_colour = shadow_colour[idx];
          r.read_depth  = shadow_depth[idx];
        end else begin
          r.status = trd_pkg::ST_OFFSCREEN;
        end
      end
      trd_pkg::MODE_CLEAR: wipe_stores();
      default: ;
    endcase
    return r;
  endfunction

  function automatic trd_pkg::in_item_t tri_item(int ax, int ay, int bx, int by, int cx,
                                                 int cy, int za, int zb, int zc,
                                                 logic [31:0] col);
    trd_pkg::in_item_t it;
    it = '0;
    it.mode = trd_pkg::MODE_DRAW;
    it.ax     = trd_pkg::COORD_W'(ax);
    it.ay     = trd_pkg::COORD_W'(ay);
    it.bx     = trd_pkg::COORD_W'(bx);
    it.by_row = trd_pkg::COORD_W'(by);
    it.cx     = trd_pkg::COORD_W'(cx);
    it.cy     = trd_pkg::COORD_W'(cy);
    it.az_inv = trd_pkg::DEPTH_W'(za);
    it.bz_inv = trd_pkg::DEPTH_W'(zb);
    it.cz_inv = trd_pkg::DEPTH_W'(zc);
    it.fill_colour = col;
    return it;
  endfunction

  function automatic trd_pkg::in_item_t read_item(int x, int y);
    trd_pkg::in_item_t it;
    it = random_item();
    it.mode = trd_pkg::MODE_READ;
    it.ax = trd_pkg::COORD_W'(x);
    it.ay = trd_pkg::COORD_W'(y);
    return it;
  endfunction

  function automatic trd_pkg::in_item_t op_item(logic [1:0] mode);
    trd_pkg::in_item_t it;
    it = random_item();
    it.mode = mode;
    return it;
  endfunction

  // Small triangle near the screen with random depths and colour
  function automatic trd_pkg::in_item_t near_triangle();
    int bx, by, s;
    bx = int'($urandom_range(0, 140)) - 8;
    by = int'($urandom_range(0, 140)) - 8;
    s  = $urandom_range(1, 12);
    return tri_item(bx + $urandom_range(0, s), by + $urandom_range(0, s),
                    bx + $urandom_range(0, s), by + $urandom_range(0, s),
                    bx + $urandom_range(0, s), by + $urandom_range(0, s),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom);
  endfunction

  // Triangle whose box lies wholly off screen, with coordinates out to the ends of the range
  function automatic trd_pkg::in_item_t far_triangle();
    trd_pkg::in_item_t it;
    it = random_item();
    it.mode = trd_pkg::MODE_DRAW;
    if ($urandom_range(0, 1)) begin
      it.ax = trd_pkg::COORD_W'($urandom_range(128, 2047));
      it.bx = trd_pkg::COORD_W'($urandom_range(128, 2047));
      it.cx = trd_pkg::COORD_W'($urandom_range(128, 2047));
    end else begin
      it.ay     = trd_pkg::COORD_W'(-int'($urandom_range(1, 2048)));
      it.by_row = trd_pkg::COORD_W'(-int'($urandom_range(1, 2048)));
      it.cy     = trd_pkg::COORD_W'(-int'($urandom_range(1, 2048)));
    end
    return it;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input driver: take transactions from the pending queue, with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(predict_result(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 40 && $urandom_range(0, 5) == 0) begin
          in_gap     <= $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: stall in random bursts, compare each transaction with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result %p", $realtime, out_data_o);
        end else begin
          automatic trd_pkg::out_item_t exp_r = expected_q.pop_front();
          if (exp_r.read_colour !== out_data_o.read_colour ||
              exp_r.read_depth !== out_data_o.read_depth ||
              exp_r.pixels_written !== out_data_o.pixels_written ||
              exp_r.status !== out_data_o.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] mismatch: expected %p, got %p", $realtime, exp_r, out_data_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap     <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (pending_q.size() > 40 && $urandom_range(0, 5) == 0) begin
        out_gap     <= $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int pick;
    mismatches = 0; results_seen = 0; cycles = 0;
    draws_sent = 0; reads_sent = 0; clears_sent = 0;
    wipe_stores();

    // Directed: corners, both windings, depth order, degenerate and off-screen cases
    pending_q.push_back(tri_item(0, 0, 5, 0, 0, 5, 1000, 2000, 3000, 32'h0000_00FF));
    pending_q.push_back(tri_item(127, 127, 127, 120, 120, 127, 65535, 65535, 65535, '1));
    pending_q.push_back(tri_item(10, 10, 20, 10, 10, 20, 500, 500, 500, 32'h1234_5678));
    pending_q.push_back(tri_item(10, 10, 10, 20, 20, 10, 400, 400, 400, 32'hDEAD_BEEF));
    pending_q.push_back(tri_item(30, 30, 40, 30, 30, 40, 0, 0, 0, 32'hAAAA_5555));
    pending_q.push_back(tri_item(1, 1, 5, 5, 9, 9, 100, 100, 100, 32'h1));
    pending_q.push_back(tri_item(3, 3, 3, 3, 3, 3, 100, 100, 100, 32'h2));
    pending_q.push_back(tri_item(200, 5, 300, 5, 250, 40, 100, 100, 100, 32'h3));
    pending_q.push_back(tri_item(-10, -10, -2, -10, -5, -1, 100, 100, 100, 32'h4));
    pending_q.push_back(read_item(0, 0));
    pending_q.push_back(read_item(127, 127));
    pending_q.push_back(read_item(12, 12));
    pending_q.push_back(read_item(31, 31));
    pending_q.push_back(read_item(-1, 5));
    pending_q.push_back(read_item(128, 0));
    pending_q.push_back(read_item(2047, -2048));
    pending_q.push_back(op_item(trd_pkg::MODE_UNUSED));
    pending_q.push_back(tri_item(-2048, -2048, 2047, -2048, -2048, 2047, 65535, 0, 65535,
                                 32'hFFFF_0000));
    pending_q.push_back(read_item(64, 64));
    pending_q.push_back(read_item(127, 0));
    pending_q.push_back(op_item(trd_pkg::MODE_CLEAR));
    pending_q.push_back(read_item(64, 64));
    pending_q.push_back(read_item(0, 0));

    // Random: mostly small draws and reads, some off-screen noise and rare clears
    for (int n = 0; n < 430; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      pending_q.push_back(near_triangle());
      else if (pick < 88) pending_q.push_back(read_item(int'($urandom_range(0, 131)) - 2,
                                                        int'($urandom_range(0, 131)) - 2));
      else if (pick < 93) pending_q.push_back(far_triangle());
      else if (pick < 96) pending_q.push_back(read_item(int'($urandom_range(0, 4095)) - 2048,
                                                        int'($urandom_range(0, 4095)) - 2048));
      else if (pick < 98) pending_q.push_back(op_item(trd_pkg::MODE_UNUSED));
      else if (n % 100 < 10) pending_q.push_back(op_item(trd_pkg::MODE_CLEAR));
      else pending_q.push_back(near_triangle());
    end
    foreach (pending_q[i]) begin
      if (pending_q[i].mode == trd_pkg::MODE_DRAW) draws_sent++;
      else if (pending_q[i].mode == trd_pkg::MODE_READ) reads_sent++;
      else if (pending_q[i].mode == trd_pkg::MODE_CLEAR) clears_sent++;
    end

    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    in_data_i   = '0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all transactions sent and every expectation met
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (expected_q.size() > 0) mismatches++;

    $display("Covered %0d draws, %0d reads and %0d clears; %0d results checked in %0d cycles",
             draws_sent, reads_sent, clears_sent, results_seen, cycles);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== triangle_raster_depth_test.f =====
sv/trd_pkg.sv
sv/triangle_raster_depth_test.sv
dv/triangle_raster_depth_test_tb.sv
